@@ hdl/sts_pkg.sv @@
// Package for the sorted table floor search block.
// Holds the controller state type, the command and status structs between
// controller and datapath, and the register and request codes. No dependencies.
package sts_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMPARE,
        ST_FINISH
    } sts_state_t;

    // Configuration register indexes.
    localparam logic [3:0] CFG_ELEMENT_COUNT  = 4'd0;
    localparam logic [3:0] CFG_COMPARE_SIGNED = 4'd1;

    // Request kinds carried by s_req_type.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic write_entry;   // store the accepted item's value in the table
        logic start_search;  // latch the key and open the search range
        logic probe;         // latch mid and read the table at it
        logic update;        // narrow the range from the compare result
        logic set_floor;     // range empty: take the floor index as result
        logic out_load;      // move the result into the output register
    } sts_cmd_t;

    typedef struct packed {
        logic range_empty;   // lo is not below hi
        logic key_equal;     // probed entry equals the key
        logic out_free;      // output register can take a result this cycle
    } sts_status_t;

endpackage

@@ hdl/sts_ctrl.sv @@
// Controller state machine of the sorted table floor search block.
// Sequences accept, probe, compare and result hand-off. Depends on sts_pkg.
module sts_ctrl
    import sts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  sts_status_t status,
    output sts_cmd_t    cmd
);

    sts_state_t state_reg;
    sts_state_t state_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_req_type == REQ_SEARCH)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = status.range_empty ? ST_FINISH : ST_COMPARE;
            end
            ST_COMPARE: begin
                state_next = status.key_equal ? ST_FINISH : ST_CHECK;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.write_entry  = accept && (s_req_type == REQ_WRITE);
                cmd.start_search = accept && (s_req_type == REQ_SEARCH);
            end
            ST_CHECK: begin
                cmd.probe     = !status.range_empty;
                cmd.set_floor = status.range_empty;
            end
            ST_COMPARE: begin
                cmd.update = 1'b1;
            end
            ST_FINISH: begin
                cmd.out_load = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

@@ hdl/sts_dp.sv @@
// Datapath of the sorted table floor search block: key memory, config
// registers, search bounds, key compare and output register. Depends on sts_pkg.
module sts_dp
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  sts_cmd_t    cmd,
    output sts_status_t status,
    input  logic [9:0]  s_entry_slot,
    input  logic [31:0] s_entry_value,
    input  logic [31:0] s_search_key,
    input  logic        cfg_valid,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_found_position
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [KEY_BITS-1:0] SIGN_BIT = {1'b1, {(KEY_BITS - 1){1'b0}}};

    logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];

    logic [10:0]         element_count_reg;
    logic                compare_signed_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] rd_data_reg;
    logic [CNT_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    hi_reg;
    logic [ADDR_W-1:0]   mid_reg;
    logic [9:0]          result_reg;
    logic                m_valid_reg;
    logic [9:0]          m_pos_reg;

    logic [CNT_W-1:0]    hi_init;
    logic [CNT_W-1:0]    mid_calc;
    logic [KEY_BITS-1:0] key_cmp;
    logic [KEY_BITS-1:0] entry_cmp;
    logic                key_less;
    logic                slot_in_range;

    assign slot_in_range = int'(s_entry_slot) < TABLE_DEPTH;
    assign hi_init = (int'(element_count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                           : CNT_W'(element_count_reg);
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    // Flipping the sign bit turns a two's complement order into an unsigned one.
    assign key_cmp   = compare_signed_reg ? (key_reg ^ SIGN_BIT) : key_reg;
    assign entry_cmp = compare_signed_reg ? (rd_data_reg ^ SIGN_BIT) : rd_data_reg;
    assign key_less  = key_cmp < entry_cmp;

    assign status.range_empty = !(lo_reg < hi_reg);
    assign status.key_equal   = (key_cmp == entry_cmp);
    assign status.out_free    = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.write_entry && slot_in_range) begin
            key_mem[ADDR_W'(s_entry_slot)] <= KEY_BITS'(s_entry_value);
        end
        if (cmd.probe) begin
            rd_data_reg <= key_mem[ADDR_W'(mid_calc)];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_count_reg  <= 11'd0;
            compare_signed_reg <= 1'b1;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ELEMENT_COUNT) begin
                element_count_reg <= cfg_data[10:0];
            end else if (cfg_index == CFG_COMPARE_SIGNED) begin
                compare_signed_reg <= cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start_search) begin
            key_reg <= KEY_BITS'(s_search_key);
            lo_reg  <= '0;
            hi_reg  <= hi_init;
        end
        if (cmd.probe) begin
            mid_reg <= ADDR_W'(mid_calc);
        end
        if (cmd.update) begin
            if (status.key_equal) begin
                result_reg <= 10'(mid_reg);
            end else if (key_less) begin
                hi_reg <= CNT_W'(mid_reg);
            end else begin
                lo_reg <= CNT_W'(mid_reg) + CNT_W'(1);
            end
        end
        if (cmd.set_floor) begin
            result_reg <= (lo_reg == '0) ? 10'd0 : 10'(lo_reg - CNT_W'(1));
        end
        if (cmd.out_load) begin
            m_pos_reg <= result_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_found_position = m_pos_reg;

endmodule

@@ hdl/sorted_table_floor_search.sv @@
// Top level of the sorted table floor search block.
// Joins the controller (sts_ctrl) and the datapath (sts_dp). Depends on sts_pkg.
//
// Usage: the s_ channel carries items. A write item (s_req_type 0) stores
// s_entry_value at s_entry_slot, no result; when idle, one is taken per cycle.
// A search item (s_req_type 1) binary-searches the first element_count
// entries for s_search_key and delivers one m_found_position on the m_
// channel: the matching index, else the greatest index below the key, else 0.
// The cfg channel writes element_count (index 0) and compare_signed
// (index 1); cfg_ready is always high and other indexes are ignored.
// Sequence: a search makes P probes (P at most 11 for 1024 entries), each
// reading the single-port key memory in ST_CHECK and then comparing and
// narrowing in ST_COMPARE; a matching probe ends it early. The result then
// waits in ST_FINISH for the output register, and the next item can be
// accepted in the same cycle in which m_valid first shows that result.
// A finished result sits in the output register; if the receiver stalls, new
// items are still taken, and a later search waits only for that register.
// Reset clears the controller, the output valid and the config registers
// (count 0, signed compare); table contents stay undefined until written.
module sorted_table_floor_search
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_BITS    = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [9:0]  s_entry_slot,
    input  logic [31:0] s_entry_value,
    input  logic [31:0] s_search_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_found_position,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    sts_cmd_t    cmd;
    sts_status_t status;

    assign cfg_ready = 1'b1;

    sts_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .status     (status),
        .cmd        (cmd)
    );

    sts_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_entry_slot     (s_entry_slot),
        .s_entry_value    (s_entry_value),
        .s_search_key     (s_search_key),
        .cfg_valid        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found_position (m_found_position)
    );

endmodule

@@ hdl/sts_checker.sv @@
// Port-level checker for the sorted table floor search block, with the bind
// that attaches it to sorted_table_floor_search. Depends on no package.
module sts_checker #(
    parameter int TABLE_DEPTH = 1024
) (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       s_req_type,
    input logic       m_valid,
    input logic       m_ready,
    input logic [9:0] m_found_position
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found_position))
        else $error("stalled result changed or dropped");

    // A write item never makes the block busy.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_req_type |=> s_ready)
        else $error("block stalled after a write item");

    // A search item keeps the block busy through ST_CHECK and the state after it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type |=> !s_ready ##1 !s_ready)
        else $error("block took an item during a search");

    // Every answer names a position inside the table.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_found_position) < TABLE_DEPTH))
        else $error("result position beyond the table");

endmodule

bind sorted_table_floor_search sts_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_sts_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_req_type       (s_req_type),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_found_position (m_found_position)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for sorted_table_floor_search: loads sorted key tables,
// runs directed and random searches under varied idling and checks every result.
// Depends on sts_pkg and the sorted_table_floor_search RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    typedef struct packed {
        logic        req_type;
        logic [9:0]  slot;
        logic [31:0] value;
        logic [31:0] key;
    } table_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = REQ_WRITE;
    logic [9:0]  s_entry_slot = '0;
    logic [31:0] s_entry_value = '0;
    logic [31:0] s_search_key = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [9:0]  m_found_position;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Stimulus and prediction state.
    table_req_t  pending_reqs[$];
    table_req_t  offered;
    logic [9:0]  expected_positions[$];
    logic [31:0] planned_keys[1024];
    logic [31:0] shadow_keys[1024];
    logic [10:0] shadow_count = 11'd0;
    logic        shadow_signed = 1'b1;
    int          reqs_queued = 0;
    int          reqs_taken = 0;
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        recv_hold = 1'b0;
    event        hold_go;

    sorted_table_floor_search i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_entry_slot     (s_entry_slot),
        .s_entry_value    (s_entry_value),
        .s_search_key     (s_search_key),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_found_position (m_found_position),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Binary search over the shadow table, exactly as the block walks it.
    function automatic logic [9:0] floor_position(logic [31:0] key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        logic [31:0] a;
        logic [31:0] b;
        lo = 0;
        hi = (shadow_count > 11'd1024) ? 1024 : shadow_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            // Flipping the sign bit turns a signed compare into an unsigned one.
            a = shadow_signed ? key ^ 32'h8000_0000 : key;
            b = shadow_signed ? shadow_keys[mid] ^ 32'h8000_0000 : shadow_keys[mid];
            if (a < b) begin
                hi = mid;
            end else if (a > b) begin
                lo = mid + 1;
            end else begin
                return 10'(mid);
            end
        end
        return (lo == 0) ? 10'd0 : 10'(lo - 1);
    endfunction

    function automatic void push_write(int slot, logic [31:0] value);
        table_req_t r;
        r.req_type = REQ_WRITE;
        r.slot = 10'(slot);
        r.value = value;
        r.key = $urandom();
        planned_keys[slot] = value;
        pending_reqs.push_back(r);
        reqs_queued++;
    endfunction

    function automatic void push_search(logic [31:0] key);
        table_req_t r;
        r.req_type = REQ_SEARCH;
        r.slot = 10'($urandom());
        r.value = $urandom();
        r.key = key;
        pending_reqs.push_back(r);
        reqs_queued++;
    endfunction

    // Writes slots 0..n-1 with random keys in ascending order for the given compare.
    function automatic void load_sorted_table(int n, logic signed_order);
        logic [31:0] vals[$];
        int span;
        span = $urandom_range(0, 1) ? 0 : 3 * n + 2;
        for (int i = 0; i < n; i++) begin
            if (span == 0) begin
                vals.push_back($urandom());
            end else begin
                // A narrow range around zero gives duplicates and both signs.
                vals.push_back(32'($urandom_range(0, span)) - 32'(span / 2));
            end
        end
        if (signed_order) begin
            foreach (vals[i]) vals[i] ^= 32'h8000_0000;
        end
        vals.sort();
        if (signed_order) begin
            foreach (vals[i]) vals[i] ^= 32'h8000_0000;
        end
        for (int i = 0; i < n; i++) push_write(i, vals[i]);
    endfunction

    function automatic logic [31:0] edge_value(int slot);
        return 32'(slot) * 32'd16 - 32'd8200;
    endfunction

    // Writes only the slots that a search over the whole table visits when the
    // key lies below or above every entry. Values ascend with the slot: negative
    // up to the middle slot and positive beyond it.
    function automatic void load_edge_paths();
        int lo;
        int mid;
        push_write(0, edge_value(0));
        for (int s = 1; s <= 512; s = s * 2) push_write(s, edge_value(s));
        lo = 513;
        while (lo < 1024) begin
            mid = lo + (1024 - lo) / 2;
            push_write(mid, edge_value(mid));
            lo = mid + 1;
        end
    endfunction

    function automatic logic [31:0] pick_key(int n);
        logic [31:0] hit;
        hit = (n > 0) ? planned_keys[$urandom_range(0, n - 1)] : $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return hit;
            4:          return hit + 32'd1;
            5:          return hit - 32'd1;
            6:          return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            7:          return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default:    return $urandom();
        endcase
    endfunction

    task automatic write_register(logic [3:0] idx, logic [31:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ELEMENT_COUNT:  shadow_count = data[10:0];
            CFG_COMPARE_SIGNED: shadow_signed = data[0];
            default: ;
        endcase
    endtask

    task automatic set_idling(int mode);
        @(posedge aclk);
        case (mode)
            0: begin
                send_idle_pct <= 0;
                recv_stall_pct <= 0;
            end
            1: begin
                send_idle_pct <= 62;
                recv_stall_pct <= 0;
            end
            2: begin
                send_idle_pct <= 0;
                recv_stall_pct <= 62;
            end
            default: begin
                send_idle_pct <= 33;
                recv_stall_pct <= 33;
            end
        endcase
    endtask

    // Waits until every item is taken and every result is in, then lets the
    // block finish any trailing write before the next register change.
    task automatic settle();
        while (reqs_taken != reqs_queued || expected_positions.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);
    endtask

    // Driver: the expectation is formed at the edge where the item is accepted.
    always @(posedge aclk) begin : req_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (offered.req_type == REQ_WRITE) begin
                    shadow_keys[offered.slot] = offered.value;
                end else begin
                    expected_positions.push_back(floor_position(offered.key));
                end
                reqs_taken++;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    offered = pending_reqs.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= offered.req_type;
                    s_entry_slot <= offered.slot;
                    s_entry_value <= offered.value;
                    s_search_key <= offered.key;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_ready
        m_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Holds the result side off for a long stretch each time it is triggered.
    initial begin : result_hold
        forever begin
            @(hold_go);
            recv_hold <= 1'b1;
            repeat (400) @(posedge aclk);
            recv_hold <= 1'b0;
        end
    end

    always @(posedge aclk) begin : result_monitor
        logic [9:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_positions.size() == 0) begin
                $error("found_position: no result expected, got %0d", m_found_position);
                mismatch_count++;
            end else begin
                want = expected_positions.pop_front();
                if (m_found_position !== want) begin
                    $error("found_position: expected %0d, got %0d", want, m_found_position);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int cnt;
        int n;
        logic sgn;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Empty table after reset: no probe is made and the answer is zero.
        push_search(32'h0000_0000);
        push_search(32'hFFFF_FFFF);
        push_search(32'h8000_0000);
        push_search(32'h7FFF_FFFF);
        settle();

        // Only the outermost search paths of the full table are written, so the
        // full-range searches below keep to written entries.
        set_idling(0);
        load_edge_paths();
        settle();

        // A count above the table depth searches the whole table.
        write_register(CFG_ELEMENT_COUNT, {21'($urandom()), 11'd2047});
        push_search(planned_keys[0]);
        push_search(planned_keys[1023]);
        push_search(planned_keys[512]);
        push_search(32'h8000_0000);
        push_search(32'h7FFF_FFFF);
        settle();

        // Unsigned compare over a table sorted as signed: the negative half
        // now ranks above the positive half.
        write_register(CFG_ELEMENT_COUNT, {21'($urandom()), 11'd1024});
        write_register(CFG_COMPARE_SIGNED, {31'($urandom()), 1'b0});
        push_search(32'h0000_0000);
        push_search(32'hFFFF_FFFF);
        settle();

        write_register(CFG_ELEMENT_COUNT, {21'($urandom()), 11'd1});
        write_register(CFG_COMPARE_SIGNED, {31'($urandom()), 1'b1});
        push_search(planned_keys[0]);
        push_search(32'h8000_0000);
        push_search(32'h7FFF_FFFF);
        settle();

        // An exact key answers its own entry; a key between two entries answers the lower one.
        write_register(CFG_ELEMENT_COUNT, {21'($urandom()), 11'd1024});
        push_search(planned_keys[1022]);
        push_search(planned_keys[1] + 32'd1);
        settle();

        // Writes to unused register indexes must leave the setup alone.
        write_register(4'd2, $urandom());
        write_register(4'd15, $urandom());
        push_search(planned_keys[1023]);
        push_search(planned_keys[256]);
        settle();

        for (int p = 0; p < 12; p++) begin
            set_idling(p % 4);
            case (p)
                10:      cnt = 0;
                default: cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
                                                           : $urandom_range(3, 30);
            endcase
            sgn = 1'($urandom_range(0, 1));
            n = cnt;
            load_sorted_table(n, sgn);
            settle();
            write_register(CFG_ELEMENT_COUNT, {21'($urandom()), 11'(cnt)});
            write_register(CFG_COMPARE_SIGNED, {31'($urandom()), sgn});
            // One phase holds the result side off long enough to stall the input.
            if (p == 6) begin
                -> hold_go;
            end
            for (int k = 0; k < 20; k++) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_write($urandom_range(0, 1023), $urandom());
                end else begin
                    push_search(pick_key(n));
                end
            end
            settle();
        end

        if (mismatch_count == 0 && expected_positions.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #(10_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/sts_pkg.sv
hdl/sts_ctrl.sv
hdl/sts_dp.sv
hdl/sorted_table_floor_search.sv
hdl/sts_checker.sv
sim/tb_top.sv
